// File: src/mau_pkg.sv
// Shared types and constants of the MIX arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package mau_pkg;

    // Default byte width and the fixed number of bytes in a word
    localparam int unsigned BYTE_BITS_DEF = 6;
    localparam int unsigned WORD_BYTES    = 5;
    localparam int unsigned WORD_BITS_DEF = BYTE_BITS_DEF * WORD_BYTES;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CAPTURE,
        ACT_ADD,
        ACT_MUL_INIT,
        ACT_MUL_STEP,
        ACT_MUL_COMMIT,
        ACT_DIV_INIT,
        ACT_DIV_STEP,
        ACT_DIV_COMMIT,
        ACT_DIV_FAULT
    } dp_act_t;

    // Controller to datapath
    typedef struct packed {
        dp_act_t act;
        logic    out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic bad;
        logic div_fault;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: src/mau_datapath.sv
// Datapath of the MIX arithmetic unit: registers, operand extraction, add and shift unit.
`timescale 1ns / 1ps
`default_nettype none

module mau_datapath #(
    parameter int unsigned BYTE_BITS = mau_pkg::BYTE_BITS_DEF
) (
    input  wire                                           aclk,
    input  wire                                           aresetn,
    input  wire  [1:0]                                    s_operation,
    input  wire                                           s_word_negative,
    input  wire  [BYTE_BITS*mau_pkg::WORD_BYTES-1:0]      s_word_magnitude,
    input  wire  [2:0]                                    s_field_left,
    input  wire  [2:0]                                    s_field_right,
    input  mau_pkg::dp_cmd_t                              cmd,
    output mau_pkg::dp_stat_t                             stat,
    output logic                                          m_acc_negative,
    output logic [BYTE_BITS*mau_pkg::WORD_BYTES-1:0]      m_acc_magnitude,
    output logic                                          m_ext_negative,
    output logic [BYTE_BITS*mau_pkg::WORD_BYTES-1:0]      m_ext_magnitude,
    output logic                                          m_overflow_flag,
    output logic                                          m_bad_field
);
    import mau_pkg::*;

    localparam int unsigned WordBits = BYTE_BITS * WORD_BYTES;
    localparam int unsigned ShW      = $clog2(WordBits + 1);

    // Architectural registers
    logic                acc_sign_reg, ext_sign_reg, ovf_reg;
    logic [WordBits-1:0] acc_mag_reg, ext_mag_reg;

    // Captured item
    op_t                 op_reg;
    logic                bad_reg;
    logic                v_neg_reg;
    logic [WordBits-1:0] vm_reg;

    // Shift unit work registers
    logic [WordBits-1:0] hi_reg, lo_reg;

    // Output registers
    logic                out_acc_neg_reg, out_ext_neg_reg, out_ovf_reg, out_bad_reg;
    logic [WordBits-1:0] out_acc_mag_reg, out_ext_mag_reg;

    // Operand extraction
    logic [2:0]          first_byte;
    logic [2:0]          shift_bytes;
    logic [ShW-1:0]      shamt;
    logic [WordBits-1:0] byte_mask;
    logic [WordBits-1:0] ext_vm;
    logic                field_bad;

    // Add and subtract
    logic                v_neg_eff;
    logic [WordBits:0]   add_sum;
    logic                add_ge;
    logic [WordBits-1:0] add_mag;
    logic                add_sign;
    logic                add_carry;

    // Multiply and divide steps
    logic [WordBits:0]   mul_sum;
    logic [WordBits:0]   div_t;
    logic [WordBits+1:0] div_d;
    logic                div_ge;

    // Select bytes max(L,1)..R and right-align them
    always_comb begin
        first_byte  = (s_field_left == 3'd0) ? 3'd1 : s_field_left;
        field_bad   = (s_field_left > s_field_right) || (s_field_right > 3'(WORD_BYTES));
        shift_bytes = 3'(WORD_BYTES) - s_field_right;
        shamt       = ShW'(shift_bytes) * ShW'(BYTE_BITS);
        for (int k = 1; k <= int'(WORD_BYTES); k++) begin
            byte_mask[(int'(WORD_BYTES) - k) * int'(BYTE_BITS) +: BYTE_BITS] =
                (3'(k) >= first_byte && 3'(k) <= s_field_right) ?
                {BYTE_BITS{1'b1}} : {BYTE_BITS{1'b0}};
        end
        ext_vm = (s_word_magnitude & byte_mask) >> shamt;
    end

    // Signed add of rA and the operand, magnitude wraps
    always_comb begin
        v_neg_eff = v_neg_reg ^ (op_reg == OP_SUB);
        add_sum   = {1'b0, acc_mag_reg} + {1'b0, vm_reg};
        add_ge    = (acc_mag_reg >= vm_reg);
        add_carry = 1'b0;
        if (acc_sign_reg == v_neg_eff) begin
            add_mag   = add_sum[WordBits-1:0];
            add_carry = add_sum[WordBits];
            add_sign  = acc_sign_reg;
        end else if (add_ge) begin
            add_mag  = acc_mag_reg - vm_reg;
            add_sign = acc_sign_reg;
        end else begin
            add_mag  = vm_reg - acc_mag_reg;
            add_sign = v_neg_eff;
        end
    end

    // One bit of shift-add multiply and restoring divide
    always_comb begin
        mul_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, acc_mag_reg} : '0);
        div_t   = {hi_reg, lo_reg[WordBits-1]};
        div_d   = {1'b0, div_t} - {2'b00, vm_reg};
        div_ge  = !div_d[WordBits+1];
    end

    assign stat.op        = op_reg;
    assign stat.bad       = bad_reg;
    assign stat.div_fault = (vm_reg == '0) || add_ge;

    // Capture the item
    always_ff @(posedge aclk) begin
        if (cmd.act == ACT_CAPTURE) begin
            op_reg    <= op_t'(s_operation);
            bad_reg   <= field_bad;
            v_neg_reg <= (s_field_left == 3'd0) ? s_word_negative : 1'b0;
            vm_reg    <= ext_vm;
        end
    end

    // Advance the shift unit
    always_ff @(posedge aclk) begin
        unique case (cmd.act)
            ACT_MUL_INIT: begin
                hi_reg <= '0;
                lo_reg <= vm_reg;
            end
            ACT_MUL_STEP: begin
                hi_reg <= mul_sum[WordBits:1];
                lo_reg <= {mul_sum[0], lo_reg[WordBits-1:1]};
            end
            ACT_DIV_INIT: begin
                hi_reg <= acc_mag_reg;
                lo_reg <= ext_mag_reg;
            end
            ACT_DIV_STEP: begin
                hi_reg <= div_ge ? div_d[WordBits-1:0] : div_t[WordBits-1:0];
                lo_reg <= {lo_reg[WordBits-2:0], div_ge};
            end
            default: begin
            end
        endcase
    end

    // Update rA, rX and the sticky overflow
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_sign_reg <= 1'b0;
            acc_mag_reg  <= '0;
            ext_sign_reg <= 1'b0;
            ext_mag_reg  <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            unique case (cmd.act)
                ACT_ADD: begin
                    if (add_mag != '0) begin
                        acc_sign_reg <= add_sign;
                    end
                    acc_mag_reg <= add_mag;
                    if (add_carry) begin
                        ovf_reg <= 1'b1;
                    end
                end
                ACT_MUL_COMMIT: begin
                    acc_sign_reg <= acc_sign_reg ^ v_neg_reg;
                    ext_sign_reg <= acc_sign_reg ^ v_neg_reg;
                    acc_mag_reg  <= hi_reg;
                    ext_mag_reg  <= lo_reg;
                end
                ACT_DIV_COMMIT: begin
                    acc_sign_reg <= acc_sign_reg ^ v_neg_reg;
                    ext_sign_reg <= acc_sign_reg;
                    acc_mag_reg  <= lo_reg;
                    ext_mag_reg  <= hi_reg;
                end
                ACT_DIV_FAULT: begin
                    ovf_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the result item for the output channel
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_acc_neg_reg <= acc_sign_reg;
            out_acc_mag_reg <= acc_mag_reg;
            out_ext_neg_reg <= ext_sign_reg;
            out_ext_mag_reg <= ext_mag_reg;
            out_ovf_reg     <= ovf_reg;
            out_bad_reg     <= bad_reg;
        end
    end

    assign m_acc_negative  = out_acc_neg_reg;
    assign m_acc_magnitude = out_acc_mag_reg;
    assign m_ext_negative  = out_ext_neg_reg;
    assign m_ext_magnitude = out_ext_mag_reg;
    assign m_overflow_flag = out_ovf_reg;
    assign m_bad_field     = out_bad_reg;

endmodule

`default_nettype wire

// File: src/mau_ctrl.sv
// Controller of the MIX arithmetic unit: sequencing state machine and bit counter.
`timescale 1ns / 1ps
`default_nettype none

module mau_ctrl #(
    parameter int unsigned STEPS = mau_pkg::WORD_BITS_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire                m_ready,
    input  mau_pkg::dp_stat_t  stat,
    output mau_pkg::dp_cmd_t   cmd
);
    import mau_pkg::*;

    localparam int unsigned CntW = $clog2(STEPS);

    state_t          state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;
    logic            cnt_last;
    logic            out_free;

    assign cnt_last = (cnt_reg == CntW'(STEPS - 1));
    assign out_free = !m_valid_reg || m_ready;

    // State, counter and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.act      = ACT_NONE;
        cmd.out_load = 1'b0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.act    = ACT_CAPTURE;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cnt_next = '0;
                if (stat.bad) begin
                    state_next = ST_FINISH;
                end else begin
                    unique case (stat.op) inside
                        OP_ADD, OP_SUB: begin
                            cmd.act    = ACT_ADD;
                            state_next = ST_FINISH;
                        end
                        OP_MUL: begin
                            cmd.act    = ACT_MUL_INIT;
                            state_next = ST_MUL;
                        end
                        default: begin
                            if (stat.div_fault) begin
                                cmd.act    = ACT_DIV_FAULT;
                                state_next = ST_FINISH;
                            end else begin
                                cmd.act    = ACT_DIV_INIT;
                                state_next = ST_DIV;
                            end
                        end
                    endcase
                end
            end
            ST_MUL: begin
                cmd.act  = ACT_MUL_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIV: begin
                cmd.act  = ACT_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.act    = (stat.op == OP_MUL) ? ACT_MUL_COMMIT : ACT_DIV_COMMIT;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Raise valid on load, drop it when the item is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// File: src/mix_arithmetic_unit_core.sv
// Top level of the MIX arithmetic unit: ADD, SUB, MUL and DIV on rA, rX and overflow.
// ADD, SUB, a bad field spec and a divide fault go from EXEC straight to FINISH; MUL and
// DIV first pass through the MUL or DIV step state and COMMIT. The shared shift-add /
// shift-subtract unit retires one bit per cycle. A new item is taken only in IDLE, once the
// last result has been loaded into the output register, even while that finished result
// still waits on the output register.
// Reset (synchronous, active low) clears rA, rX, overflow and all control state.
`timescale 1ns / 1ps
`default_nettype none

module mix_arithmetic_unit_core #(
    parameter int unsigned BYTE_BITS = mau_pkg::BYTE_BITS_DEF
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire                                       s_valid,
    output logic                                      s_ready,
    input  wire  [1:0]                                s_operation,
    input  wire                                       s_word_negative,
    input  wire  [BYTE_BITS*mau_pkg::WORD_BYTES-1:0]  s_word_magnitude,
    input  wire  [2:0]                                s_field_left,
    input  wire  [2:0]                                s_field_right,
    output logic                                      m_valid,
    input  wire                                       m_ready,
    output logic                                      m_acc_negative,
    output logic [BYTE_BITS*mau_pkg::WORD_BYTES-1:0]  m_acc_magnitude,
    output logic                                      m_ext_negative,
    output logic [BYTE_BITS*mau_pkg::WORD_BYTES-1:0]  m_ext_magnitude,
    output logic                                      m_overflow_flag,
    output logic                                      m_bad_field
);
    import mau_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mau_ctrl #(
        .STEPS(BYTE_BITS * WORD_BYTES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mau_datapath #(
        .BYTE_BITS(BYTE_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_operation      (s_operation),
        .s_word_negative  (s_word_negative),
        .s_word_magnitude (s_word_magnitude),
        .s_field_left     (s_field_left),
        .s_field_right    (s_field_right),
        .cmd              (cmd),
        .stat             (stat),
        .m_acc_negative   (m_acc_negative),
        .m_acc_magnitude  (m_acc_magnitude),
        .m_ext_negative   (m_ext_negative),
        .m_ext_magnitude  (m_ext_magnitude),
        .m_overflow_flag  (m_overflow_flag),
        .m_bad_field      (m_bad_field)
    );

    // One item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result loaded over a pending item");

    // Divide iterations start only on a valid field and a non-faulting divisor
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.act == ACT_DIV_INIT) |-> (!stat.div_fault && !stat.bad && stat.op == OP_DIV))
        else $error("divide started on a faulting operand");

    // Multiply steps belong to a multiply item
    a_mul_step_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.act == ACT_MUL_STEP) |-> (stat.op == OP_MUL && !stat.bad))
        else $error("multiply step on a non-multiply item");

endmodule

`default_nettype wire

// File: dv/tb_mix_arithmetic_unit_core.sv
// Self-checking testbench for mix_arithmetic_unit_core: ADD, SUB, MUL and DIV on rA, rX, overflow.
`timescale 1ns / 1ps

module tb_mix_arithmetic_unit_core;
    import mau_pkg::*;

    localparam int W            = WORD_BITS_DEF;
    localparam int W2           = 2 * W;
    localparam int RANDOM_ITEMS = 800;
    localparam int IDLE_PCT     = 16;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 40;
    localparam logic [W-1:0] MAG_ALL = '1;

    // One instruction as offered on the input channel
    typedef struct {
        op_t          op;
        logic         neg;
        logic [W-1:0] mag;
        logic [2:0]   left;
        logic [2:0]   right;
        bit           drain_first;
    } mix_instr_t;

    // Architectural registers as seen on the result channel
    typedef struct {
        logic         acc_neg;
        logic [W-1:0] acc_mag;
        logic         ext_neg;
        logic [W-1:0] ext_mag;
        logic         ovf;
        logic         bad;
    } mix_regs_t;

    logic         aclk             = 1'b0;
    logic         aresetn          = 1'b0;
    logic         s_valid          = 1'b0;
    logic         s_ready;
    logic [1:0]   s_operation      = '0;
    logic         s_word_negative  = 1'b0;
    logic [W-1:0] s_word_magnitude = '0;
    logic [2:0]   s_field_left     = '0;
    logic [2:0]   s_field_right    = '0;
    logic         m_valid;
    logic         m_ready          = 1'b0;
    logic         m_acc_negative;
    logic [W-1:0] m_acc_magnitude;
    logic         m_ext_negative;
    logic [W-1:0] m_ext_magnitude;
    logic         m_overflow_flag;
    logic         m_bad_field;

    mix_instr_t pending_instr[$];
    mix_regs_t  expected_regs[$];
    mix_regs_t  model_regs = '{default: '0};

    int   accepted_cnt = 0;
    int   results_seen = 0;
    int   stall_cycles = 0;
    int   mismatch_cnt = 0;
    int   bad_cnt      = 0;
    int   op_cnt[4]    = '{default: 0};
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;
    logic in_taken     = 1'b0;
    logic all_drained  = 1'b0;
    logic calm;

    // No idling on either side through a stretch of the random part
    assign calm = (accepted_cnt >= 450) && (accepted_cnt < 600);

    mix_arithmetic_unit_core #(
        .BYTE_BITS(BYTE_BITS_DEF)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_word_negative (s_word_negative),
        .s_word_magnitude(s_word_magnitude),
        .s_field_left    (s_field_left),
        .s_field_right   (s_field_right),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_acc_negative  (m_acc_negative),
        .m_acc_magnitude (m_acc_magnitude),
        .m_ext_negative  (m_ext_negative),
        .m_ext_magnitude (m_ext_magnitude),
        .m_overflow_flag (m_overflow_flag),
        .m_bad_field     (m_bad_field)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Execute one instruction on a copy of rA, rX and overflow
    function automatic mix_regs_t exec_mix(mix_regs_t cur, mix_instr_t ins);
        mix_regs_t     nxt;
        int            first;
        int            nbytes;
        logic [W2-1:0] wide;
        logic [W2-1:0] mask;
        logic [W-1:0]  vm;
        logic [W-1:0]  rm;
        logic [W:0]    sum;
        logic          vs;
        logic          rs;
        nxt = cur;
        nxt.bad = (ins.left > ins.right) || (ins.right > WORD_BYTES);
        if (nxt.bad) begin
            return nxt;
        end
        // Take bytes max(L,1)..R, right-aligned; sign only when L is 0
        first  = (ins.left == 0) ? 1 : ins.left;
        nbytes = (ins.right >= first) ? (ins.right - first + 1) : 0;
        wide   = W2'(ins.mag) >> ((WORD_BYTES - ins.right) * BYTE_BITS_DEF);
        mask   = (W2'(1) << (nbytes * BYTE_BITS_DEF)) - 1;
        vm     = W'(wide & mask);
        vs     = (ins.left == 0) ? ins.neg : 1'b0;
        case (ins.op) inside
            OP_ADD, OP_SUB: begin
                if (ins.op == OP_SUB) begin
                    vs = ~vs;
                end
                rs = cur.acc_neg;
                if (cur.acc_neg == vs) begin
                    sum = cur.acc_mag + vm;
                    if (sum[W]) begin
                        nxt.ovf = 1'b1;
                    end
                    rm = sum[W-1:0];
                end else if (cur.acc_mag >= vm) begin
                    rm = cur.acc_mag - vm;
                end else begin
                    rm = vm - cur.acc_mag;
                    rs = vs;
                end
                // A zero magnitude keeps the old sign
                if (rm != 0) begin
                    nxt.acc_neg = rs;
                end
                nxt.acc_mag = rm;
            end
            OP_MUL: begin
                wide        = W2'(cur.acc_mag) * W2'(vm);
                nxt.acc_neg = cur.acc_neg ^ vs;
                nxt.ext_neg = nxt.acc_neg;
                nxt.acc_mag = wide[W2-1:W];
                nxt.ext_mag = wide[W-1:0];
            end
            default: begin
                // Divide fault leaves rA and rX alone
                if (vm == 0 || cur.acc_mag >= vm) begin
                    nxt.ovf = 1'b1;
                end else begin
                    wide        = {cur.acc_mag, cur.ext_mag};
                    nxt.ext_neg = cur.acc_neg;
                    nxt.acc_neg = cur.acc_neg ^ vs;
                    nxt.acc_mag = W'(wide / W2'(vm));
                    nxt.ext_mag = W'(wide % W2'(vm));
                end
            end
        endcase
        return nxt;
    endfunction

    function automatic void add_instr(op_t op, logic neg, logic [W-1:0] mag,
                                      logic [2:0] l, logic [2:0] r, bit drain_first);
        mix_instr_t ins;
        ins = '{op: op, neg: neg, mag: mag, left: l, right: r, drain_first: drain_first};
        pending_instr.push_back(ins);
    endfunction

    function automatic logic [W-1:0] rand_mag();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return MAG_ALL;
            2: return W'($urandom_range(0, 63));
            default: return W'($urandom());
        endcase
    endfunction

    // Well-formed field spec, or any L and R when noisy
    function automatic void pick_field(output logic [2:0] l, output logic [2:0] r,
                                       input bit noisy);
        if (noisy) begin
            l = 3'($urandom_range(0, 7));
            r = 3'($urandom_range(0, 7));
        end else begin
            r = 3'($urandom_range(0, WORD_BYTES));
            l = 3'($urandom_range(0, r));
        end
    endfunction

    task automatic check_field(string name, logic [W-1:0] want, logic [W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Drive the next item at the falling edge; hold it until accepted
    always @(negedge aclk) begin
        mix_instr_t ins;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_instr.size() != 0 && pending_instr[0].drain_first &&
                expected_regs.size() != 0) begin
                s_valid <= 1'b0;
            end else if (pending_instr.size() != 0 &&
                         (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                ins = pending_instr.pop_front();
                s_valid          <= 1'b1;
                s_operation      <= ins.op;
                s_word_negative  <= ins.neg;
                s_word_magnitude <= ins.mag;
                s_field_left     <= ins.left;
                s_field_right    <= ins.right;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check accepted results, then predict accepted items
    always @(posedge aclk) begin
        mix_instr_t ins;
        mix_regs_t  want;
        logic       took_in;
        logic       took_out;
        took_in  = aresetn && s_valid && s_ready;
        took_out = aresetn && m_valid && m_ready;
        if (took_out) begin
            results_seen <= results_seen + 1;
            if (expected_regs.size() == 0) begin
                $error("result item with no instruction pending");
                mismatch_cnt++;
            end else begin
                want = expected_regs.pop_front();
                check_field("acc_negative", W'(want.acc_neg), W'(m_acc_negative));
                check_field("acc_magnitude", want.acc_mag, m_acc_magnitude);
                check_field("ext_negative", W'(want.ext_neg), W'(m_ext_negative));
                check_field("ext_magnitude", want.ext_mag, m_ext_magnitude);
                check_field("overflow_flag", W'(want.ovf), W'(m_overflow_flag));
                check_field("bad_field", W'(want.bad), W'(m_bad_field));
            end
        end
        if (took_in) begin
            ins = '{op: op_t'(s_operation), neg: s_word_negative, mag: s_word_magnitude,
                    left: s_field_left, right: s_field_right, drain_first: 1'b0};
            model_regs = exec_mix(model_regs, ins);
            expected_regs.push_back(model_regs);
            op_cnt[ins.op]++;
            if (model_regs.bad) begin
                bad_cnt++;
            end
            accepted_cnt <= accepted_cnt + 1;
        end
        in_taken     <= took_in;
        stall_cycles <= (took_in || took_out) ? 0 : stall_cycles + 1;
        all_drained  <= (pending_instr.size() == 0) && !s_valid && (expected_regs.size() == 0);
    end

    // Fill the item queue, release reset, wait for the last result
    initial begin
        int         made;
        int         pick;
        bit         mark;
        logic [2:0] l;
        logic [2:0] r;
        logic [W-1:0] mag;
        logic       neg;

        // Directed part: extremes and corner cases
        add_instr(OP_ADD, 1'b0, MAG_ALL, 3'd1, 3'd5, 1'b0);
        add_instr(OP_ADD, 1'b0, W'(1), 3'd1, 3'd5, 1'b0);            // wrap to zero
        add_instr(OP_ADD, 1'b1, MAG_ALL, 3'd0, 3'd0, 1'b0);          // sign-only field
        add_instr(OP_SUB, 1'b0, MAG_ALL, 3'd3, 3'd3, 1'b0);          // goes negative
        add_instr(OP_ADD, 1'b0, W'(100), 3'd0, 3'd5, 1'b0);          // larger operand wins
        add_instr(OP_ADD, 1'b1, W'(37), 3'd0, 3'd5, 1'b0);           // zero sum keeps sign
        add_instr(OP_SUB, 1'b1, W'(5), 3'd0, 3'd5, 1'b0);
        add_instr(OP_MUL, 1'b0, MAG_ALL, 3'd1, 3'd5, 1'b0);
        add_instr(OP_DIV, 1'b0, MAG_ALL, 3'd1, 3'd5, 1'b0);
        add_instr(OP_DIV, 1'b1, MAG_ALL, 3'd0, 3'd0, 1'b0);          // zero divisor
        add_instr(OP_DIV, 1'b0, W'(1), 3'd5, 3'd5, 1'b0);            // rA not below divisor
        add_instr(OP_MUL, 1'b1, 30'h2AAAAAAA, 3'd0, 3'd5, 1'b0);
        add_instr(OP_MUL, 1'b1, 30'h15555555, 3'd0, 3'd5, 1'b0);
        add_instr(OP_MUL, 1'b1, 30'h00123456, 3'd0, 3'd5, 1'b0);
        add_instr(OP_DIV, 1'b1, 30'h00123456, 3'd0, 3'd5, 1'b0);
        add_instr(OP_DIV, 1'b0, 30'h0ABCDEF1, 3'd2, 3'd4, 1'b0);
        add_instr(OP_ADD, 1'b0, MAG_ALL, 3'd4, 3'd5, 1'b0);
        add_instr(OP_SUB, 1'b0, 30'h3F000000, 3'd1, 3'd1, 1'b0);
        add_instr(OP_ADD, 1'b1, '0, 3'd0, 3'd5, 1'b0);               // minus zero
        add_instr(OP_ADD, 1'b0, MAG_ALL, 3'd3, 3'd2, 1'b0);          // L above R
        add_instr(OP_MUL, 1'b1, MAG_ALL, 3'd0, 3'd6, 1'b0);          // R past the word
        add_instr(OP_DIV, 1'b1, MAG_ALL, 3'd7, 3'd7, 1'b0);
        add_instr(OP_SUB, 1'b0, MAG_ALL, 3'd6, 3'd5, 1'b0);
        add_instr(OP_ADD, 1'b1, MAG_ALL, 3'd0, 3'd7, 1'b0);

        // Random part; the first item waits for the directed results
        made = 0;
        mark = 1'b1;
        while (made < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            mag  = rand_mag();
            neg  = 1'($urandom_range(0, 1));
            if (pick < 35) begin
                // Multiply then divide by the same operand: the divide succeeds unless the operand is zero
                pick_field(l, r, 1'b0);
                add_instr(OP_MUL, neg, mag, l, r, mark);
                add_instr(OP_DIV, 1'($urandom_range(0, 1)), mag, l, r, 1'b0);
                made += 2;
            end else begin
                pick_field(l, r, pick >= 90);
                add_instr(op_t'($urandom_range(0, 3)), neg, mag, l, r, mark);
                if (l <= r && r <= WORD_BYTES) begin
                    made++;
                end
            end
            mark = 1'b0;
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk); while (!all_drained);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Ran %0d instructions (%0d add, %0d sub, %0d mul, %0d div), %0d bad field specs,",
                 accepted_cnt, op_cnt[OP_ADD], op_cnt[OP_SUB], op_cnt[OP_MUL], op_cnt[OP_DIV],
                 bad_cnt);
        $display("checked %0d results through random stalls, one long output hold and a drain pause.",
                 results_seen);
        if (mismatch_cnt == 0) begin
            $display("mix_arithmetic_unit_core regression: pass");
        end else begin
            $display("mix_arithmetic_unit_core regression: fail");
        end
        $finish;
    end

    // End the run when neither channel moves for too long
    initial begin
        do @(negedge aclk); while (stall_cycles < STALL_LIMIT);
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("mix_arithmetic_unit_core regression: fail");
        $finish;
    end

endmodule
